// ===== hdl/hsatd_pkg.sv =====
// Package for the 8x8 Hadamard SATD block: widths, lane types, lane control struct.
// No dependencies; every other file uses it by scoped names.
`default_nettype none

package hsatd_pkg;

  // Geometry of one block
  localparam int Lanes  = 8;
  localparam int PixW   = 8;
  localparam int RowW   = $clog2(Lanes);
  localparam int RowBits = Lanes * PixW;

  // Arithmetic widths: diff 9b, row transform 12b, vertical accumulators 15b
  localparam int HorW     = 12;
  localparam int AccW     = 15;
  localparam int LaneSumW = 17;
  localparam int TotW     = 20;
  localparam int CostW    = 15;

  // Rounding of the final cost
  localparam int RoundAdd = 2;
  localparam int RoundSh  = 2;

  localparam logic [RowW-1:0] LastRow = RowW'(Lanes - 1);

  typedef logic signed [HorW-1:0] hor_t;
  typedef logic signed [AccW-1:0] acc_t;
  typedef logic [LaneSumW-1:0]    lane_sum_t;

  // Control shared by all column lanes
  typedef struct packed {
    logic            acc_en;  // fold the staged row into the accumulators
    logic            last;    // staged row is the eighth of its block
    logic [RowW-1:0] row;     // row index of the staged row
    logic            sum_ld;  // snapshot moves on into the lane sum register
  } lane_ctl_t;

  // Sign of a Hadamard term: odd parity of the AND of the two indexes
  function automatic logic odd_parity(input logic [RowW-1:0] v);
    return ^v;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/hsatd_in_if.sv =====
// Input channel: one row of original and predicted pixels per transaction.
// Depends on hsatd_pkg.
`default_nettype none

interface hsatd_in_if;
  logic                            valid;
  logic                            ready;
  logic [hsatd_pkg::RowBits-1:0]   org_pixels;
  logic [hsatd_pkg::RowBits-1:0]   pred_pixels;

  modport source (output valid, output org_pixels, output pred_pixels, input ready);
  modport sink   (input valid, input org_pixels, input pred_pixels, output ready);
endinterface

`default_nettype wire

// ===== hdl/hsatd_out_if.sv =====
// Output channel: one SATD cost per transaction.
// Depends on hsatd_pkg.
`default_nettype none

interface hsatd_out_if;
  logic                          valid;
  logic                          ready;
  logic [hsatd_pkg::CostW-1:0]   satd_cost;

  modport source (output valid, output satd_cost, input ready);
  modport sink   (input valid, input satd_cost, output ready);
endinterface

`default_nettype wire

// ===== hdl/hsatd_row_xform.sv =====
// Row stage: pixel differences and 8-point Hadamard transform in natural order.
// Depends on hsatd_pkg. Purely combinational; the top level registers the result.
`default_nettype none

module hsatd_row_xform (
  input  wire logic [hsatd_pkg::RowBits-1:0] org_pixels,
  input  wire logic [hsatd_pkg::RowBits-1:0] pred_pixels,
  output hsatd_pkg::hor_t                    hor [hsatd_pkg::Lanes]
);

  localparam int Stages = hsatd_pkg::RowW;
  localparam int PadW   = hsatd_pkg::HorW - hsatd_pkg::PixW;

  hsatd_pkg::hor_t x [Stages+1][hsatd_pkg::Lanes];

  // Differences, then one butterfly stage per index bit
  always_comb begin
    for (int i = 0; i < hsatd_pkg::Lanes; i++) begin
      x[0][i] = hsatd_pkg::hor_t'({{PadW{1'b0}}, org_pixels[i*hsatd_pkg::PixW +: hsatd_pkg::PixW]})
              - hsatd_pkg::hor_t'({{PadW{1'b0}}, pred_pixels[i*hsatd_pkg::PixW +: hsatd_pkg::PixW]});
    end
    for (int s = 0; s < Stages; s++) begin
      for (int i = 0; i < hsatd_pkg::Lanes; i++) begin
        if ((i & (1 << s)) == 0) begin
          x[s+1][i]            = x[s][i] + x[s][i + (1 << s)];
          x[s+1][i + (1 << s)] = x[s][i] - x[s][i + (1 << s)];
        end
      end
    end
    for (int i = 0; i < hsatd_pkg::Lanes; i++) begin
      hor[i] = x[Stages][i];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/hsatd_lane.sv =====
// Column lane: eight vertical-transform accumulators for one row coefficient,
// a snapshot bank for the finished block and a registered sum of magnitudes.
// Depends on hsatd_pkg.
`default_nettype none

module hsatd_lane (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire hsatd_pkg::lane_ctl_t  ctl,
  input  wire hsatd_pkg::hor_t       hor,
  output hsatd_pkg::lane_sum_t       lane_sum
);

  hsatd_pkg::acc_t      acc  [hsatd_pkg::Lanes];
  hsatd_pkg::acc_t      snap [hsatd_pkg::Lanes];
  hsatd_pkg::acc_t      acc_next [hsatd_pkg::Lanes];
  hsatd_pkg::acc_t      hor_ext;
  hsatd_pkg::lane_sum_t sum_next;

  // Vertical fold: add or subtract by parity of (k AND row)
  always_comb begin
    hor_ext = hsatd_pkg::acc_t'(hor);
    for (int k = 0; k < hsatd_pkg::Lanes; k++) begin
      if (hsatd_pkg::odd_parity(hsatd_pkg::RowW'(k) & ctl.row)) begin
        acc_next[k] = acc[k] - hor_ext;
      end else begin
        acc_next[k] = acc[k] + hor_ext;
      end
    end
  end

  // Sum of magnitudes of the snapshot
  always_comb begin
    logic [hsatd_pkg::AccW-1:0] mag;
    sum_next = '0;
    for (int k = 0; k < hsatd_pkg::Lanes; k++) begin
      mag      = snap[k][hsatd_pkg::AccW-1] ? unsigned'(-snap[k]) : unsigned'(snap[k]);
      sum_next = sum_next + hsatd_pkg::LaneSumW'(mag);
    end
  end

  // Accumulators clear on reset and after the eighth row
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < hsatd_pkg::Lanes; k++) acc[k] <= '0;
    end else if (ctl.acc_en) begin
      for (int k = 0; k < hsatd_pkg::Lanes; k++) begin
        acc[k] <= ctl.last ? '0 : acc_next[k];
      end
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk) begin
    if (ctl.acc_en && ctl.last) begin
      for (int k = 0; k < hsatd_pkg::Lanes; k++) snap[k] <= acc_next[k];
    end
    if (ctl.sum_ld) begin
      lane_sum <= sum_next;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/hadamard_satd_8x8.sv =====
// Top level of the 8x8 Hadamard SATD block: row stage, eight column lanes, merge stage.
// Depends on hsatd_pkg, hsatd_in_if, hsatd_out_if, hsatd_row_xform, hsatd_lane.
//
// Channel   Direction  Payload                      Transaction
// row_in    sink       org_pixels, pred_pixels      one row of the block
// cost_out  source     satd_cost                    one cost per eight rows
//
// One row is taken per cycle unless the row stage is stalled. The cost of a block
// passes from its eighth row through the row register, snapshot bank and lane sum
// register, then the merge into the output register. Synchronous reset clears the
// row counter, the accumulators and all valid flags. A stalled output holds its cost;
// rows keep flowing until the eighth row of a block finds the snapshot bank still occupied.
`default_nettype none

module hadamard_satd_8x8 (
  input  wire logic     clk,
  input  wire logic     rst,
  hsatd_in_if.sink      row_in,
  hsatd_out_if.source   cost_out
);

  hsatd_pkg::hor_t      hor_c [hsatd_pkg::Lanes];
  hsatd_pkg::hor_t      hor_q [hsatd_pkg::Lanes];
  hsatd_pkg::lane_sum_t lane_sum [hsatd_pkg::Lanes];
  hsatd_pkg::lane_ctl_t ctl;

  logic                          a_vld;
  logic [hsatd_pkg::RowW-1:0]    a_row;
  logic [hsatd_pkg::RowW-1:0]    row_cnt;
  logic                          snap_vld;
  logic                          c_vld;
  logic                          out_vld;
  logic [hsatd_pkg::CostW-1:0]   cost;
  logic                          a_last, a_move, snap_move, c_move, accept;
  logic [hsatd_pkg::TotW-1:0]    total;

  hsatd_row_xform u_row (
    .org_pixels  (row_in.org_pixels),
    .pred_pixels (row_in.pred_pixels),
    .hor         (hor_c)
  );

  // Flow control along the result chain
  always_comb begin
    a_last    = (a_row == hsatd_pkg::LastRow);
    c_move    = c_vld && (!out_vld || cost_out.ready);
    snap_move = snap_vld && (!c_vld || c_move);
    a_move    = a_vld && !(a_last && snap_vld && !snap_move);
    accept    = row_in.valid && row_in.ready;
  end

  assign row_in.ready       = !a_vld || a_move;
  assign cost_out.valid     = out_vld;
  assign cost_out.satd_cost = cost;

  assign ctl = '{acc_en: a_move, last: a_last, row: a_row, sum_ld: snap_move};

  for (genvar c = 0; c < hsatd_pkg::Lanes; c++) begin : g_lane
    hsatd_lane u_lane (
      .clk      (clk),
      .rst      (rst),
      .ctl      (ctl),
      .hor      (hor_q[c]),
      .lane_sum (lane_sum[c])
    );
  end

  // Merge the lane sums
  always_comb begin
    total = '0;
    for (int c = 0; c < hsatd_pkg::Lanes; c++) begin
      total = total + hsatd_pkg::TotW'(lane_sum[c]);
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld    <= 1'b0;
      a_row    <= '0;
      row_cnt  <= '0;
      snap_vld <= 1'b0;
      c_vld    <= 1'b0;
      out_vld  <= 1'b0;
    end else begin
      if (accept) begin
        a_vld   <= 1'b1;
        a_row   <= row_cnt;
        row_cnt <= row_cnt + 1'b1;
      end else if (a_move) begin
        a_vld <= 1'b0;
      end
      snap_vld <= (snap_vld && !snap_move) || (a_move && a_last);
      c_vld    <= (c_vld && !c_move) || snap_move;
      out_vld  <= (out_vld && !cost_out.ready) || c_move;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      hor_q <= hor_c;
    end
    if (c_move) begin
      cost <= hsatd_pkg::CostW'((total + hsatd_pkg::TotW'(hsatd_pkg::RoundAdd))
                                >> hsatd_pkg::RoundSh);
    end
  end

endmodule

`default_nettype wire

// ===== sim/hadamard_satd_8x8_test.sv =====
// Testbench for hadamard_satd_8x8: directed rows, then random rows under four handshake modes.
// Depends on hsatd_pkg, hsatd_in_if, hsatd_out_if and the hadamard_satd_8x8 RTL.
`default_nettype none

module hadamard_satd_8x8_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RowsPerPhase = 128;
  localparam int NumPhases    = 4;
  localparam int HoldCycles   = 150;
  localparam int DrainCycles  = 12;
  localparam int CycleLimit   = 200000;

  typedef struct {
    logic [hsatd_pkg::RowBits-1:0] org;
    logic [hsatd_pkg::RowBits-1:0] pred;
    bit                            fixed;  // cost typed in below, not predicted
    logic [hsatd_pkg::CostW-1:0]   cost;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst;

  hsatd_in_if  row_in ();
  hsatd_out_if cost_out ();

  hadamard_satd_8x8 dut (
    .clk      (clk),
    .rst      (rst),
    .row_in   (row_in),
    .cost_out (cost_out)
  );

  always #10 clk = ~clk;

  // Predictor state: vertical transform accumulators and row position
  int                         coef_acc [64];
  logic [hsatd_pkg::RowW-1:0] block_row;

  logic [hsatd_pkg::CostW-1:0] pending_costs [$];

  // Sideband that travels with each offered row
  bit                          tag_fixed;
  logic [hsatd_pkg::CostW-1:0] tag_cost;

  int  errors;
  int  rows_taken;
  int  costs_checked;
  int  cycles;
  int  recv_stall_pct;
  bit  long_hold;
  int  send_idle_pct;

  stim_row_t directed_rows [24];

  // Fold one row into the 8x8 Hadamard accumulators; returns 1 on the block's last row
  function automatic bit fold_row(input logic [hsatd_pkg::RowBits-1:0] org,
                                  input logic [hsatd_pkg::RowBits-1:0] pred,
                                  output logic [hsatd_pkg::CostW-1:0] cost);
    int          diff [8];
    int          hor [8];
    int unsigned total;
    bit          last;
    for (int i = 0; i < hsatd_pkg::Lanes; i++) begin
      diff[i] = int'(org[hsatd_pkg::PixW*i +: hsatd_pkg::PixW])
              - int'(pred[hsatd_pkg::PixW*i +: hsatd_pkg::PixW]);
    end
    // horizontal transform, natural order
    for (int c = 0; c < hsatd_pkg::Lanes; c++) begin
      hor[c] = 0;
      for (int i = 0; i < hsatd_pkg::Lanes; i++) begin
        hor[c] += ($countones(c & i) % 2) ? -diff[i] : diff[i];
      end
    end
    // vertical transform, one row term at a time
    for (int k = 0; k < hsatd_pkg::Lanes; k++) begin
      for (int c = 0; c < hsatd_pkg::Lanes; c++) begin
        coef_acc[k*hsatd_pkg::Lanes+c] +=
          ($countones(k & int'(block_row)) % 2) ? -hor[c] : hor[c];
      end
    end
    last = (block_row == hsatd_pkg::LastRow);
    cost = '0;
    if (last) begin
      total = 0;
      foreach (coef_acc[n]) begin
        total += (coef_acc[n] < 0) ? -coef_acc[n] : coef_acc[n];
        coef_acc[n] = 0;
      end
      cost = hsatd_pkg::CostW'((total + hsatd_pkg::RoundAdd) >> hsatd_pkg::RoundSh);
      block_row = '0;
    end else begin
      block_row = block_row + 1'b1;
    end
    return last;
  endfunction

  // Scoreboard: check output transactions, then predict from input transactions
  always @(posedge clk) begin
    logic [hsatd_pkg::CostW-1:0] exp_cost;
    logic [hsatd_pkg::CostW-1:0] got_cost;
    if (!rst) begin
      if (cost_out.valid && cost_out.ready) begin
        if (pending_costs.size() == 0) begin
          $error("satd_cost: unexpected transaction, expected none, actual %0d",
                 cost_out.satd_cost);
          errors++;
        end else begin
          exp_cost = pending_costs.pop_front();
          costs_checked++;
          if (cost_out.satd_cost !== exp_cost) begin
            $error("satd_cost mismatch: expected %0d, actual %0d", exp_cost,
                   cost_out.satd_cost);
            errors++;
          end
        end
      end
      if (row_in.valid && row_in.ready) begin
        rows_taken++;
        if (fold_row(row_in.org_pixels, row_in.pred_pixels, got_cost)) begin
          pending_costs.push_back(tag_fixed ? tag_cost : got_cost);
        end
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off counted here
  always @(posedge clk) begin
    int hold_left;
    bit hold_done;
    if (long_hold && !hold_done) begin
      hold_left = HoldCycles;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      cost_out.ready <= 1'b0;
    end else begin
      cost_out.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Offer one row until it is taken; the caller decides whether valid drops afterwards
  task automatic offer_row(input logic [hsatd_pkg::RowBits-1:0] org,
                           input logic [hsatd_pkg::RowBits-1:0] pred,
                           input bit fixed, input logic [hsatd_pkg::CostW-1:0] cost);
    while ($urandom_range(99) < send_idle_pct) begin
      row_in.valid <= 1'b0;
      @(posedge clk);
    end
    row_in.valid       <= 1'b1;
    row_in.org_pixels  <= org;
    row_in.pred_pixels <= pred;
    tag_fixed          <= fixed;
    tag_cost           <= cost;
    @(posedge clk);
    while (!row_in.ready) @(posedge clk);
  endtask

  task automatic wait_drained();
    row_in.valid <= 1'b0;
    @(posedge clk);
    while (pending_costs.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  initial begin
    logic [hsatd_pkg::RowBits-1:0] org;
    logic [hsatd_pkg::RowBits-1:0] pred;
    logic [hsatd_pkg::PixW-1:0]    pix;
    int                            kind;
    int                            row_pos;
    bit                            neg;

    rst                  = 1'b1;
    row_in.valid         = 1'b0;
    row_in.org_pixels    = '0;
    row_in.pred_pixels   = '0;
    cost_out.ready       = 1'b0;
    tag_fixed            = 1'b0;
    tag_cost             = '0;
    recv_stall_pct       = 0;
    send_idle_pct        = 0;
    long_hold            = 1'b0;
    block_row            = '0;
    foreach (coef_acc[n]) coef_acc[n] = 0;

    // Directed blocks: zero difference, flat +255 difference, bent +-255 pattern (max cost)
    for (int r = 0; r < hsatd_pkg::Lanes; r++) begin
      directed_rows[r] = '{{hsatd_pkg::RowBits{r[0]}}, {hsatd_pkg::RowBits{r[0]}},
                           r == hsatd_pkg::Lanes-1, hsatd_pkg::CostW'(0)};
      directed_rows[hsatd_pkg::Lanes+r] = '{{hsatd_pkg::RowBits{1'b1}}, '0,
                                            r == hsatd_pkg::Lanes-1,
                                            hsatd_pkg::CostW'(4080)};
      for (int i = 0; i < hsatd_pkg::Lanes; i++) begin
        org[hsatd_pkg::PixW*i +: hsatd_pkg::PixW] = ($countones(r & i) % 2) ? 8'h00 : 8'hFF;
      end
      directed_rows[2*hsatd_pkg::Lanes+r] = '{org, ~org, r == hsatd_pkg::Lanes-1,
                                              hsatd_pkg::CostW'(32640)};
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[n]) begin
      offer_row(directed_rows[n].org, directed_rows[n].pred, 1'b0, '0);
    end
    wait_drained();

    // Rerun the typed rows with the sideband set so those costs are compared as typed
    foreach (directed_rows[n]) begin
      offer_row(directed_rows[n].org, directed_rows[n].pred, directed_rows[n].fixed,
                directed_rows[n].cost);
    end
    wait_drained();

    // Random part: four handshake modes, whole blocks per phase
    for (int ph = 0; ph < NumPhases; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct <= 0;  long_hold <= 1'b1; end
        1: begin send_idle_pct = 68; recv_stall_pct <= 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct <= 68; end
        default: begin send_idle_pct = 6; recv_stall_pct <= 6; end
      endcase
      kind = 0;
      for (int n = 0; n < RowsPerPhase; n++) begin
        row_pos = n % hsatd_pkg::Lanes;
        if (row_pos == 0) kind = $urandom_range(0, 4);
        for (int i = 0; i < hsatd_pkg::Lanes; i++) begin
          pix = hsatd_pkg::PixW'($urandom_range(0, 255));
          case (kind)
            0: begin
              org[hsatd_pkg::PixW*i +: hsatd_pkg::PixW]  = pix;
              pred[hsatd_pkg::PixW*i +: hsatd_pkg::PixW] =
                hsatd_pkg::PixW'($urandom_range(0, 255));
            end
            1: begin
              org[hsatd_pkg::PixW*i +: hsatd_pkg::PixW]  = {hsatd_pkg::PixW{pix[0]}};
              pred[hsatd_pkg::PixW*i +: hsatd_pkg::PixW] = {hsatd_pkg::PixW{pix[1]}};
            end
            2: begin
              org[hsatd_pkg::PixW*i +: hsatd_pkg::PixW]  = pix;
              pred[hsatd_pkg::PixW*i +: hsatd_pkg::PixW] =
                pix ^ hsatd_pkg::PixW'($urandom_range(0, 7));
            end
            3: begin
              org[hsatd_pkg::PixW*i +: hsatd_pkg::PixW]  = pix;
              pred[hsatd_pkg::PixW*i +: hsatd_pkg::PixW] = pix;
            end
            default: begin
              // Hadamard-shaped rows push the cost toward its ceiling
              neg = ($countones(row_pos & i) % 2) != 0;
              org[hsatd_pkg::PixW*i +: hsatd_pkg::PixW]  = neg ? 8'h00 : 8'hFF;
              pred[hsatd_pkg::PixW*i +: hsatd_pkg::PixW] = neg ? 8'hFF : 8'h00;
            end
          endcase
        end
        if (kind == 4 && $urandom_range(0, 3) == 0) begin
          {org, pred} = {pred, org};
        end
        offer_row(org, pred, 1'b0, '0);
      end
      // sender pauses until every expected cost has come
      wait_drained();
    end

    $display("Covered %0d rows (%0d blocks) and checked %0d costs over four handshake modes,",
             rows_taken, rows_taken / hsatd_pkg::Lanes, costs_checked);
    $display("including a %0d-cycle output hold-off that backed up the row input.", HoldCycles);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
